[rtl/core/se2tw_pkg.sv]
// Shared constants and helpers for the SE(2) pose update pipeline.
package se2tw_pkg;

    // Default parameter values.
    localparam int ANGLE_FRAC_BITS_DEF = 28;
    localparam int CORDIC_STAGES_DEF   = 24;

    // Q30 constants used by the angle reduction and the CORDIC.
    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_TWO_PI  = 64'sd6746518852;
    localparam longint Q30_GAIN    = 64'sd652032874;

    // Quotient bits produced by each ratio divider, one bit per stage.
    localparam int DIV_STEPS = 31;

    // Reset value of the small angle limit register.
    localparam logic [15:0] LIMIT_RESET = 16'd1;

    // Arctangent of 2^-idx in Q30.
    function automatic logic signed [31:0] atan_q30(input int idx);
        logic signed [31:0] v;
        case (idx)
            0:       v = 32'sd843314856;
            1:       v = 32'sd497837829;
            2:       v = 32'sd263043836;
            3:       v = 32'sd133525158;
            4:       v = 32'sd67021686;
            5:       v = 32'sd33543515;
            6:       v = 32'sd16775850;
            7:       v = 32'sd8388437;
            8:       v = 32'sd4194282;
            9:       v = 32'sd2097149;
            10:      v = 32'sd1048575;
            11:      v = 32'sd524287;
            12:      v = 32'sd262143;
            13:      v = 32'sd131071;
            14:      v = 32'sd65535;
            15:      v = 32'sd32767;
            16:      v = 32'sd16383;
            17:      v = 32'sd8191;
            18:      v = 32'sd4095;
            19:      v = 32'sd2047;
            20:      v = 32'sd1023;
            21:      v = 32'sd511;
            22:      v = 32'sd255;
            23:      v = 32'sd127;
            24:      v = 32'sd63;
            25:      v = 32'sd31;
            26:      v = 32'sd15;
            27:      v = 32'sd8;
            28:      v = 32'sd4;
            29:      v = 32'sd2;
            30:      v = 32'sd1;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Clamp a wide sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat_i32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = 32'(v);
        end
        return r;
    endfunction

    // True when a wide sum lies outside the signed 32-bit range.
    function automatic logic ovf_i32(input logic signed [39:0] v);
        return (v > 40'sd2147483647) || (v < -40'sd2147483648);
    endfunction

endpackage

[rtl/core/se2tw_sincos.sv]
// Pipelined sine and cosine: modulo two-pi reduction, quadrant fold and CORDIC stages.
module se2tw_sincos #(
    parameter int AFB = se2tw_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int NCS = se2tw_pkg::CORDIC_STAGES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [61-AFB:0]    i_angle,
    output logic signed [31:0]        o_sin,
    output logic signed [31:0]        o_cos
);

    localparam int AW = 62 - AFB;
    localparam int RW = AW + 1;
    localparam int NR = 31 - AFB;
    localparam int ZW = 36;
    localparam int XW = 34;

    logic signed [RW-1:0] a_ext;
    logic        [RW-1:0] a_mag;
    logic                 a_neg;

    logic [RW-1:0] r_red_mag [NR];
    logic          r_red_neg [NR];

    logic signed [ZW-1:0] f_r0, f_r1, f_r2;
    logic                 f_flip;
    logic signed [ZW-1:0] r_fz;
    logic                 r_fflip;

    logic signed [XW-1:0] r_cx [NCS];
    logic signed [XW-1:0] r_cy [NCS];
    logic signed [ZW-1:0] r_cz [NCS];
    logic                 r_cf [NCS];

    // Magnitude and sign of the incoming Q30 angle.
    assign a_ext = RW'(i_angle);
    assign a_neg = a_ext < 0;
    assign a_mag = a_neg ? RW'(-a_ext) : RW'(a_ext);

    // Reduction: one conditional subtract of a shifted two-pi per stage.
    for (genvar j = 0; j < NR; j++) begin : g_red
        logic [RW-1:0] m_in;
        logic [RW-1:0] tsh;
        logic          s_in;
        if (j == 0) begin : g_first
            assign m_in = a_mag;
            assign s_in = a_neg;
        end else begin : g_next
            assign m_in = r_red_mag[j-1];
            assign s_in = r_red_neg[j-1];
        end
        assign tsh = RW'(se2tw_pkg::Q30_TWO_PI) << (NR - 1 - j);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_red_mag[j] <= (m_in >= tsh) ? (m_in - tsh) : m_in;
                r_red_neg[j] <= s_in;
            end
        end
    end

    // Wrap into [-pi, pi] and fold into [-pi/2, pi/2].
    always_comb begin
        f_r0 = signed'(ZW'(r_red_mag[NR-1]));
        if (r_red_neg[NR-1]) begin
            f_r0 = -f_r0;
        end
        f_r1 = f_r0;
        if (f_r0 > ZW'(se2tw_pkg::Q30_PI)) begin
            f_r1 = f_r0 - ZW'(se2tw_pkg::Q30_TWO_PI);
        end else if (f_r0 < -ZW'(se2tw_pkg::Q30_PI)) begin
            f_r1 = f_r0 + ZW'(se2tw_pkg::Q30_TWO_PI);
        end
        f_r2   = f_r1;
        f_flip = 1'b0;
        if (f_r1 > ZW'(se2tw_pkg::Q30_HALF_PI)) begin
            f_r2   = f_r1 - ZW'(se2tw_pkg::Q30_PI);
            f_flip = 1'b1;
        end else if (f_r1 < -ZW'(se2tw_pkg::Q30_HALF_PI)) begin
            f_r2   = f_r1 + ZW'(se2tw_pkg::Q30_PI);
            f_flip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fz    <= f_r2;
            r_fflip <= f_flip;
        end
    end

    // Rotation-mode CORDIC, one micro-rotation per stage.
    for (genvar i = 0; i < NCS; i++) begin : g_cordic
        logic signed [XW-1:0] x_in, y_in, xs, ys;
        logic signed [ZW-1:0] z_in, at;
        logic                 f_in;
        if (i == 0) begin : g_first
            assign x_in = XW'(se2tw_pkg::Q30_GAIN);
            assign y_in = '0;
            assign z_in = r_fz;
            assign f_in = r_fflip;
        end else begin : g_next
            assign x_in = r_cx[i-1];
            assign y_in = r_cy[i-1];
            assign z_in = r_cz[i-1];
            assign f_in = r_cf[i-1];
        end
        assign xs = x_in >>> i;
        assign ys = y_in >>> i;
        assign at = ZW'(se2tw_pkg::atan_q30(i));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (z_in >= 0) begin
                    r_cx[i] <= x_in - ys;
                    r_cy[i] <= y_in + xs;
                    r_cz[i] <= z_in - at;
                end else begin
                    r_cx[i] <= x_in + ys;
                    r_cy[i] <= y_in - xs;
                    r_cz[i] <= z_in + at;
                end
                r_cf[i] <= f_in;
            end
        end
    end

    // Undo the quadrant fold.
    assign o_sin = r_cf[NCS-1] ? 32'(-r_cy[NCS-1]) : 32'(r_cy[NCS-1]);
    assign o_cos = r_cf[NCS-1] ? 32'(-r_cx[NCS-1]) : 32'(r_cx[NCS-1]);

endmodule

[rtl/core/se2tw_div.sv]
// Pipelined restoring divider for the ratio terms, one quotient bit per stage.
module se2tw_div #(
    parameter int NW = 62,
    parameter int DW = 34
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic [NW-1:0]                        i_num,
    input  logic [DW-1:0]                        i_den,
    output logic [se2tw_pkg::DIV_STEPS-1:0]      o_quo,
    output logic                                 o_ovf
);

    localparam int QB = se2tw_pkg::DIV_STEPS;
    localparam int XW = (NW > DW + QB + 1) ? NW : DW + QB + 1;

    logic [NW-1:0] r_rem [QB];
    logic [DW-1:0] r_den [QB];
    logic [QB-1:0] r_q   [QB];
    logic          r_ovf [QB];

    for (genvar j = 0; j < QB; j++) begin : g_step
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QB-1:0] q_in;
        logic          ovf_in;
        logic [XW-1:0] dsh;
        logic          hit;
        if (j == 0) begin : g_first
            // A quotient of 2^QB or more only needs to be flagged.
            assign rem_in = i_num;
            assign den_in = i_den;
            assign q_in   = '0;
            assign ovf_in = XW'(i_num) >= (XW'(i_den) << QB);
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign den_in = r_den[j-1];
            assign q_in   = r_q[j-1];
            assign ovf_in = r_ovf[j-1];
        end
        assign dsh = XW'(den_in) << (QB - 1 - j);
        assign hit = XW'(rem_in) >= dsh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= hit ? NW'(XW'(rem_in) - dsh) : rem_in;
                r_den[j] <= den_in;
                r_q[j]   <= q_in | (QB'(hit) << (QB - 1 - j));
                r_ovf[j] <= ovf_in;
            end
        end
    end

    assign o_quo = r_q[QB-1];
    assign o_ovf = r_ovf[QB-1];

endmodule

[rtl/core/se2_twist_exponential_pose.sv]
// SE(2) exponential-map pose update, fully pipelined top level.
//
// Input channel: i_in_valid with the pose and twist words; a word is taken at
// a rising edge where i_in_valid is high and o_in_stall is low. Output channel:
// o_out_valid with the new pose and the saturation flag; the receiver holds
// i_out_stall high to keep the current word in place.
// Configuration: i_cfg_valid/o_cfg_ready write the 16-bit small angle limit;
// o_cfg_ready is always high. Write it only while the pipeline is empty.
// Throughput is one word per cycle while the output is not stalled. The pipeline
// depth comes from the two-pi reduction stages, the CORDIC stages and the
// 31-stage ratio dividers, plus the registers around them.
// A stall on the output freezes the whole pipeline at once: o_in_stall rises in
// the same cycle, and nothing is dropped or repeated.
// Reset clears all valid bits and loads the limit with 1.
module se2_twist_exponential_pose #(
    parameter int ANGLE_FRAC_BITS = se2tw_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = se2tw_pkg::CORDIC_STAGES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic signed [31:0]  i_pose_x,
    input  logic signed [31:0]  i_pose_y,
    input  logic signed [31:0]  i_pose_heading,
    input  logic signed [31:0]  i_twist_dx,
    input  logic signed [31:0]  i_twist_dy,
    input  logic signed [31:0]  i_twist_dtheta,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic signed [31:0]  o_new_x,
    output logic signed [31:0]  o_new_y,
    output logic signed [31:0]  o_new_heading,
    output logic                o_saturated,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);

    localparam int AW   = 62 - ANGLE_FRAC_BITS;
    localparam int NR   = 31 - ANGLE_FRAC_BITS;
    localparam int SCL  = NR + 1 + CORDIC_STAGES;
    localparam int DVL  = se2tw_pkg::DIV_STEPS;
    localparam int LAT  = SCL + DVL + 8;
    localparam int E_IX = SCL + DVL + 2;
    localparam int TW   = 47 - ANGLE_FRAC_BITS;
    localparam int SQW  = 2 * TW - 31;
    localparam int RN   = SQW + 3;
    localparam int RK   = (2 ** RN + 5) / 6;
    localparam int NW   = 62;

    typedef struct packed {
        logic signed [31:0]    px;
        logic signed [31:0]    py;
        logic signed [31:0]    dx;
        logic signed [31:0]    dy;
        logic signed [31:0]    nh;
        logic                  sath;
        logic                  taylor;
        logic signed [AW-1:0]  d;
        logic        [SQW-1:0] sq;
        logic signed [31:0]    ct;
    } t_side1;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] sh;
        logic signed [31:0] ch;
        logic signed [31:0] nh;
        logic               sath;
    } t_post;

    typedef struct packed {
        t_post              p;
        logic               taylor;
        logic signed [31:0] st;
        logic signed [31:0] ct;
        logic               sneg;
        logic               cneg;
    } t_side2;

    logic             en;
    logic [LAT-1:0]   r_vld;
    logic [15:0]      r_limit;

    logic signed [31:0] r_a_px, r_a_py, r_a_ph, r_a_dx, r_a_dy, r_a_dt;

    logic signed [AW-1:0]    a_d, a_h;
    logic        [31:0]      a_mag;
    logic                    a_taylor;
    logic signed [TW-1:0]    a_dl;
    logic signed [2*TW-1:0]  a_dsq;
    logic signed [32:0]      a_nh;
    t_side1                  n_s1;
    t_side1                  r_s1 [SCL];

    logic signed [31:0] sc_ds, sc_dc, sc_hs, sc_hc;

    t_side1               c_s;
    logic        [AW-1:0] c_dmag;
    logic                 c_dneg;
    logic        [31:0]   c_svm;
    logic signed [32:0]   c_cn;
    logic        [32:0]   c_cnm;
    logic [SQW+RN-1:0]    c_tmul;
    t_side2               n_s2;
    logic [NW-1:0]        r_c_ns, r_c_nc;
    logic [AW-1:0]        r_c_den;
    t_side2               r_s2 [DVL+1];

    logic [DVL-1:0]       dv_qs, dv_qc;
    logic                 dv_os, dv_oc;

    t_side2               e_s;
    logic signed [31:0]   e_qs, e_qc, e_sv, e_cv;
    logic signed [31:0]   r_e_s, r_e_c;
    t_post                r_e_p;

    logic signed [63:0]   r_f_m0, r_f_m1, r_f_m2, r_f_m3;
    t_post                r_f_p;

    logic signed [63:0]   g_sx, g_sy;
    logic signed [33:0]   r_g_ox, r_g_oy;
    t_post                r_g_p;

    logic signed [65:0]   r_h_m0, r_h_m1, r_h_m2, r_h_m3;
    t_post                r_h_p;

    logic signed [36:0]   r_i_rx, r_i_ry;
    t_post                r_i_p;

    logic signed [39:0]   o_sx, o_sy;
    logic signed [31:0]   r_o_x, r_o_y, r_o_h;
    logic                 r_o_sat;

    // Global advance: the pipeline moves unless a finished word is held.
    assign en          = !(r_vld[LAT-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[LAT-1];
    assign o_cfg_ready = 1'b1;

    // Valid bits shift along with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in_valid};
        end
    end

    // Small angle limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= se2tw_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_limit <= i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_px <= i_pose_x;
            r_a_py <= i_pose_y;
            r_a_ph <= i_pose_heading;
            r_a_dx <= i_twist_dx;
            r_a_dy <= i_twist_dy;
            r_a_dt <= i_twist_dtheta;
        end
    end

    // Q30 angles, path choice, Taylor square and the new heading.
    always_comb begin
        a_d      = AW'(r_a_dt) <<< (30 - ANGLE_FRAC_BITS);
        a_h      = AW'(r_a_ph) <<< (30 - ANGLE_FRAC_BITS);
        a_mag    = r_a_dt[31] ? 32'(-r_a_dt) : 32'(r_a_dt);
        a_taylor = (r_a_dt == 0) || (a_mag < 32'(r_limit));
        // The Taylor path only sees small angles, so a narrow copy suffices.
        a_dl     = TW'(a_d);
        a_dsq    = (2 * TW)'(a_dl) * (2 * TW)'(a_dl);
        a_nh     = 33'(r_a_ph) + 33'(r_a_dt);

        n_s1.px     = r_a_px;
        n_s1.py     = r_a_py;
        n_s1.dx     = r_a_dx;
        n_s1.dy     = r_a_dy;
        n_s1.nh     = se2tw_pkg::sat_i32(40'(a_nh));
        n_s1.sath   = se2tw_pkg::ovf_i32(40'(a_nh));
        n_s1.taylor = a_taylor;
        n_s1.d      = a_d;
        n_s1.sq     = SQW'(a_dsq >>> 30);
        n_s1.ct     = 32'(a_dl >>> 1);
    end

    // Side data waits while the sine and cosine are formed.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1[0] <= n_s1;
            for (int i = 1; i < SCL; i++) begin
                r_s1[i] <= r_s1[i-1];
            end
        end
    end

    se2tw_sincos #(
        .AFB (ANGLE_FRAC_BITS),
        .NCS (CORDIC_STAGES)
    ) u_sc_twist (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (a_d),
        .o_sin   (sc_ds),
        .o_cos   (sc_dc)
    );

    se2tw_sincos #(
        .AFB (ANGLE_FRAC_BITS),
        .NCS (CORDIC_STAGES)
    ) u_sc_head (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (a_h),
        .o_sin   (sc_hs),
        .o_cos   (sc_hc)
    );

    // Divider operands as magnitudes with signs, and the Taylor S term.
    always_comb begin
        c_s    = r_s1[SCL-1];
        c_dneg = c_s.d < 0;
        c_dmag = c_dneg ? AW'(-c_s.d) : AW'(c_s.d);
        c_svm  = sc_ds[31] ? 32'(-sc_ds) : 32'(sc_ds);
        c_cn   = 33'(se2tw_pkg::Q30_ONE) - 33'(sc_dc);
        c_cnm  = c_cn[32] ? 33'(-c_cn) : 33'(c_cn);
        c_tmul = (SQW + RN)'(c_s.sq) * (SQW + RN)'(RK);

        n_s2.p.px   = c_s.px;
        n_s2.p.py   = c_s.py;
        n_s2.p.dx   = c_s.dx;
        n_s2.p.dy   = c_s.dy;
        n_s2.p.sh   = sc_hs;
        n_s2.p.ch   = sc_hc;
        n_s2.p.nh   = c_s.nh;
        n_s2.p.sath = c_s.sath;
        n_s2.taylor = c_s.taylor;
        n_s2.st     = 32'(se2tw_pkg::Q30_ONE) - 32'(c_tmul >> RN);
        n_s2.ct     = c_s.ct;
        n_s2.sneg   = sc_ds[31] ^ c_dneg;
        n_s2.cneg   = c_cn[32] ^ c_dneg;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_ns  <= NW'(c_svm) << 30;
            r_c_nc  <= NW'(c_cnm) << 30;
            r_c_den <= c_dmag;
            r_s2[0] <= n_s2;
            for (int i = 1; i <= DVL; i++) begin
                r_s2[i] <= r_s2[i-1];
            end
        end
    end

    se2tw_div #(
        .NW (NW),
        .DW (AW)
    ) u_div_s (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_c_ns),
        .i_den (r_c_den),
        .o_quo (dv_qs),
        .o_ovf (dv_os)
    );

    se2tw_div #(
        .NW (NW),
        .DW (AW)
    ) u_div_c (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_c_nc),
        .i_den (r_c_den),
        .o_quo (dv_qc),
        .o_ovf (dv_oc)
    );

    // Clamp the ratios to one, restore signs and choose the Taylor forms.
    always_comb begin
        e_s  = r_s2[DVL];
        e_qs = (dv_os || (32'(dv_qs) > 32'(se2tw_pkg::Q30_ONE))) ?
               32'(se2tw_pkg::Q30_ONE) : 32'(dv_qs);
        e_qc = (dv_oc || (32'(dv_qc) > 32'(se2tw_pkg::Q30_ONE))) ?
               32'(se2tw_pkg::Q30_ONE) : 32'(dv_qc);
        e_sv = e_s.sneg ? -e_qs : e_qs;
        e_cv = e_s.cneg ? -e_qc : e_qc;
        if (e_s.taylor) begin
            e_sv = e_s.st;
            e_cv = e_s.ct;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e_s <= e_sv;
            r_e_c <= e_cv;
            r_e_p <= e_s.p;
        end
    end

    // Body offset products.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f_m0 <= 64'(r_e_p.dx) * 64'(r_e_s);
            r_f_m1 <= 64'(r_e_p.dy) * 64'(r_e_c);
            r_f_m2 <= 64'(r_e_p.dx) * 64'(r_e_c);
            r_f_m3 <= 64'(r_e_p.dy) * 64'(r_e_s);
            r_f_p  <= r_e_p;
        end
    end

    // Body offset.
    assign g_sx = r_f_m0 - r_f_m1;
    assign g_sy = r_f_m2 + r_f_m3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_ox <= 34'(g_sx >>> 30);
            r_g_oy <= 34'(g_sy >>> 30);
            r_g_p  <= r_f_p;
        end
    end

    // Rotation products by the heading.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_m0 <= 66'(r_g_ox) * 66'(r_g_p.ch);
            r_h_m1 <= 66'(r_g_oy) * 66'(r_g_p.sh);
            r_h_m2 <= 66'(r_g_ox) * 66'(r_g_p.sh);
            r_h_m3 <= 66'(r_g_oy) * 66'(r_g_p.ch);
            r_h_p  <= r_g_p;
        end
    end

    // Rotated offset, each product shifted on its own.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_i_rx <= 37'(r_h_m0 >>> 30) - 37'(r_h_m1 >>> 30);
            r_i_ry <= 37'(r_h_m2 >>> 30) + 37'(r_h_m3 >>> 30);
            r_i_p  <= r_h_p;
        end
    end

    // Final sums with saturation, held in the output register.
    assign o_sx = 40'(r_i_p.px) + 40'(r_i_rx);
    assign o_sy = 40'(r_i_p.py) + 40'(r_i_ry);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_o_x   <= se2tw_pkg::sat_i32(o_sx);
            r_o_y   <= se2tw_pkg::sat_i32(o_sy);
            r_o_h   <= r_i_p.nh;
            r_o_sat <= r_i_p.sath || se2tw_pkg::ovf_i32(o_sx) || se2tw_pkg::ovf_i32(o_sy);
        end
    end

    assign o_new_x       = r_o_x;
    assign o_new_y       = r_o_y;
    assign o_new_heading = r_o_h;
    assign o_saturated   = r_o_sat;

    // A set flag means at least one field sits at a range limit.
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
        (o_new_x == 32'sh7fffffff || o_new_x == 32'sh80000000 ||
         o_new_y == 32'sh7fffffff || o_new_y == 32'sh80000000 ||
         o_new_heading == 32'sh7fffffff || o_new_heading == 32'sh80000000))
        else $error("saturation flag without a clamped field");

    // The chosen S term never exceeds one in magnitude.
    a_s_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[E_IX] |->
        (r_e_s <= 32'sd1073741824 && r_e_s >= -32'sd1073741824))
        else $error("S ratio out of range");

endmodule
